/* rtl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, codes and the control record of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_MAX       = 31;
    localparam int FRAC_W         = 5;
    localparam int RWID_W         = 6;
    localparam int ADDR_W         = 4;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_SQRT = 3'd4;
    localparam logic [2:0] OP_ABS  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_DZ    = 2'd2;
    localparam logic [1:0] ST_NROOT = 2'd3;

    localparam logic [1:0] REG_FRAC  = 2'd0;
    localparam logic [1:0] REG_RWID  = 2'd1;
    localparam logic [1:0] REG_CHKEN = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic       sgn;
        logic       qneg;
        logic       zdiv;
        logic       nroot;
    } ctl_t;

endpackage

/* rtl/fixed_point_alu_range_check_core.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu_range_check_core
// Pipelined fixed-point ALU with divide, square root and result range check.
// ----------------------------------------------------------------------------
// One operation is taken every cycle while the output is not stalled:
// three front stages prepare operands and multiply, DATA_WIDTH + 31 stages
// each retire one quotient bit (the root stages run alongside in the first
// half of them), and two back stages correct the quotient, range-check and
// wrap. An output stall freezes the whole pipeline; configuration registers
// are read live and should change only while the pipeline is empty.
module fixed_point_alu_range_check_core #(
    parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fpa_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    operation,
    input  logic signed [31:0]            first_operand,
    input  logic signed [31:0]            second_operand,
    input  logic                          first_signed,
    input  logic                          second_signed,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            result_value,
    output logic                          result_is_signed,
    output logic [1:0]                    status
);

    localparam int W  = DATA_WIDTH;
    localparam int DW = W + fpa_pkg::FRAC_MAX;
    localparam int VW = DW + 1;
    localparam int RH = (DW + 1) / 2;
    localparam int RW = 2 * RH;
    localparam int K  = DW;

    // configuration registers
    logic [fpa_pkg::FRAC_W-1:0] frac_bits_reg;
    logic [fpa_pkg::FRAC_W-1:0] frac_bits_next;
    logic [fpa_pkg::RWID_W-1:0] result_width_reg;
    logic [fpa_pkg::RWID_W-1:0] result_width_next;
    logic                       range_check_enable_reg;
    logic                       range_check_enable_next;
    logic                       wr;

    always_comb
    begin
        wr                      = psel && penable && pwrite && pready;
        frac_bits_next          = frac_bits_reg;
        result_width_next       = result_width_reg;
        range_check_enable_next = range_check_enable_reg;
        if (wr)
        begin
            case (paddr[3:2])
                fpa_pkg::REG_FRAC:  frac_bits_next          = pwdata[fpa_pkg::FRAC_W-1:0];
                fpa_pkg::REG_RWID:  result_width_next       = pwdata[fpa_pkg::RWID_W-1:0];
                fpa_pkg::REG_CHKEN: range_check_enable_next = pwdata[0];
                default:            frac_bits_next          = frac_bits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_bits_reg          <= fpa_pkg::FRAC_W'(16);
            result_width_reg       <= fpa_pkg::RWID_W'(32);
            range_check_enable_reg <= 1'b1;
        end
        else
        begin
            frac_bits_reg          <= frac_bits_next;
            result_width_reg       <= result_width_next;
            range_check_enable_reg <= range_check_enable_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            fpa_pkg::REG_FRAC:  prdata = 32'(frac_bits_reg);
            fpa_pkg::REG_RWID:  prdata = 32'(result_width_reg);
            fpa_pkg::REG_CHKEN: prdata = 32'(range_check_enable_reg);
            default:            prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // whole pipeline advances unless a finished result is held
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    logic                 vld_c  [0:K];
    fpa_pkg::ctl_t        ctl_c  [0:K];
    logic signed [VW-1:0] v_c    [0:K];
    logic [W-1:0]         d_c    [0:K];
    logic [W-1:0]         rem_c  [0:K];
    logic [DW-1:0]        q_c    [0:K];
    logic [RH+1:0]        srem_c [0:K];
    logic [RH-1:0]        root_c [0:K];
    logic [RW-1:0]        rad_c  [0:K];

    fpa_front #(
        .W (W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (in_valid),
        .operation      (operation),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .first_signed   (first_signed),
        .second_signed  (second_signed),
        .frac_bits      (frac_bits_reg),
        .out_valid      (vld_c[0]),
        .out_ctl        (ctl_c[0]),
        .out_v          (v_c[0]),
        .out_d          (d_c[0]),
        .out_q          (q_c[0]),
        .out_rad        (rad_c[0])
    );

    assign rem_c[0]  = '0;
    assign srem_c[0] = '0;
    assign root_c[0] = '0;

    for (genvar k = 0; k < K; k++)
    begin : g_step
        fpa_step #(
            .W       (W),
            .DO_SQRT (k < RH)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (vld_c[k]),
            .in_ctl   (ctl_c[k]),
            .in_v     (v_c[k]),
            .in_d     (d_c[k]),
            .in_rem   (rem_c[k]),
            .in_q     (q_c[k]),
            .in_srem  (srem_c[k]),
            .in_root  (root_c[k]),
            .in_rad   (rad_c[k]),
            .out_valid(vld_c[k+1]),
            .out_ctl  (ctl_c[k+1]),
            .out_v    (v_c[k+1]),
            .out_d    (d_c[k+1]),
            .out_rem  (rem_c[k+1]),
            .out_q    (q_c[k+1]),
            .out_srem (srem_c[k+1]),
            .out_root (root_c[k+1]),
            .out_rad  (rad_c[k+1])
        );
    end

    fpa_back #(
        .W (W)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .en                 (en),
        .in_valid           (vld_c[K]),
        .in_ctl             (ctl_c[K]),
        .in_v               (v_c[K]),
        .in_rem             (rem_c[K]),
        .in_q               (q_c[K]),
        .in_root            (root_c[K]),
        .result_width       (result_width_reg),
        .range_check_enable (range_check_enable_reg),
        .out_valid          (out_valid),
        .result_value       (result_value),
        .result_is_signed   (result_is_signed),
        .status             (status)
    );

    // divide by zero and negative root always return zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == fpa_pkg::ST_DZ) |-> (result_value == '0))
        else $error("divide by zero with nonzero result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == fpa_pkg::ST_NROOT) |-> (result_value == '0))
        else $error("negative root with nonzero result");

    // overflow is only flagged with the check enabled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == fpa_pkg::ST_RANGE) |-> range_check_enable_reg)
        else $error("range overflow flagged with check disabled");

endmodule

/* rtl/fpa_front.sv */
// ----------------------------------------------------------------------------
// fpa_front
// Operand preparation, add/sub/abs, multiply and divider/root setup.
// ----------------------------------------------------------------------------
module fpa_front #(
    parameter int W = fpa_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [2:0]                           operation,
    input  logic signed [31:0]                   first_operand,
    input  logic signed [31:0]                   second_operand,
    input  logic                                 first_signed,
    input  logic                                 second_signed,
    input  logic [fpa_pkg::FRAC_W-1:0]           frac_bits,
    output logic                                 out_valid,
    output fpa_pkg::ctl_t                        out_ctl,
    output logic signed [W+fpa_pkg::FRAC_MAX:0]  out_v,
    output logic [W-1:0]                         out_d,
    output logic [W+fpa_pkg::FRAC_MAX-1:0]       out_q,
    output logic [2*((W+fpa_pkg::FRAC_MAX+1)/2)-1:0] out_rad
);

    localparam int DW = W + fpa_pkg::FRAC_MAX;
    localparam int VW = DW + 1;
    localparam int RW = 2 * ((DW + 1) / 2);

    // stage a: operand prep
    logic signed [W-1:0]   aw;
    logic signed [W-1:0]   bw;
    logic [W-1:0]          absa;
    logic [W-1:0]          absb;
    logic signed [W:0]     simple;
    fpa_pkg::ctl_t         ctl_a_next;

    logic                  valid_a_reg;
    fpa_pkg::ctl_t         ctl_a_reg;
    logic signed [W:0]     simple_a_reg;
    logic signed [W-1:0]   aw_a_reg;
    logic signed [W-1:0]   bw_a_reg;
    logic [W-1:0]          absa_a_reg;
    logic [W-1:0]          absb_a_reg;

    always_comb
    begin
        aw   = first_operand[W-1:0];
        bw   = second_operand[W-1:0];
        absa = aw[W-1] ? (~aw + 1'b1) : aw;
        absb = bw[W-1] ? (~bw + 1'b1) : bw;
        ctl_a_next.op    = operation;
        ctl_a_next.qneg  = aw[W-1] ^ bw[W-1];
        ctl_a_next.zdiv  = (bw == '0);
        ctl_a_next.nroot = aw[W-1];
        simple = '0;
        case (operation)
            fpa_pkg::OP_ADD:
            begin
                simple = (W+1)'(aw) + (W+1)'(bw);
                ctl_a_next.sgn = first_signed | second_signed;
            end
            fpa_pkg::OP_SUB:
            begin
                simple = (W+1)'(aw) - (W+1)'(bw);
                ctl_a_next.sgn = 1'b1;
            end
            fpa_pkg::OP_MUL, fpa_pkg::OP_DIV:
            begin
                ctl_a_next.sgn = first_signed | second_signed;
            end
            fpa_pkg::OP_SQRT:
            begin
                ctl_a_next.sgn = first_signed;
            end
            fpa_pkg::OP_ABS:
            begin
                simple = $signed({1'b0, absa});
                ctl_a_next.sgn = first_signed;
            end
            default:
            begin
                ctl_a_next.sgn = 1'b0;
            end
        endcase
    end

    // stage b: multiply and shifted dividend / radicand
    logic                      valid_b_reg;
    fpa_pkg::ctl_t             ctl_b_reg;
    logic signed [W:0]         simple_b_reg;
    logic signed [2*W-1:0]     prod_b_reg;
    logic [DW-1:0]             div_b_reg;
    logic [RW-1:0]             rad_b_reg;
    logic [W-1:0]              absb_b_reg;
    logic signed [2*W-1:0]     prod_next;
    logic [DW-1:0]             div_next;
    logic [RW-1:0]             rad_next;

    always_comb
    begin
        prod_next = aw_a_reg * bw_a_reg;
        div_next  = DW'(absa_a_reg) << frac_bits;
        rad_next  = RW'(absa_a_reg) << frac_bits;
    end

    // stage c: floor shift of the product
    logic signed [2*W-1:0] mshift;
    logic signed [VW-1:0]  v_next;

    always_comb
    begin
        mshift = prod_b_reg >>> frac_bits;
        if (ctl_b_reg.op == fpa_pkg::OP_MUL)
        begin
            v_next = VW'(mshift);
        end
        else
        begin
            v_next = VW'(simple_b_reg);
        end
    end

    logic valid_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_a_reg    <= ctl_a_next;
            simple_a_reg <= simple;
            aw_a_reg     <= aw;
            bw_a_reg     <= bw;
            absa_a_reg   <= absa;
            absb_a_reg   <= absb;

            ctl_b_reg    <= ctl_a_reg;
            simple_b_reg <= simple_a_reg;
            prod_b_reg   <= prod_next;
            div_b_reg    <= div_next;
            rad_b_reg    <= rad_next;
            absb_b_reg   <= absb_a_reg;

            out_ctl      <= ctl_b_reg;
            out_v        <= v_next;
            out_d        <= absb_b_reg;
            out_q        <= div_b_reg;
            out_rad      <= rad_b_reg;
        end
    end

    assign out_valid = valid_c_reg;

endmodule

/* rtl/fpa_step.sv */
// ----------------------------------------------------------------------------
// fpa_step
// One pipeline stage: one restoring divide step and, with DO_SQRT, one root step.
// ----------------------------------------------------------------------------
module fpa_step #(
    parameter int W       = fpa_pkg::DATA_WIDTH_DEF,
    parameter bit DO_SQRT = 1'b1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  fpa_pkg::ctl_t                        in_ctl,
    input  logic signed [W+fpa_pkg::FRAC_MAX:0]  in_v,
    input  logic [W-1:0]                         in_d,
    input  logic [W-1:0]                         in_rem,
    input  logic [W+fpa_pkg::FRAC_MAX-1:0]       in_q,
    input  logic [(W+fpa_pkg::FRAC_MAX+1)/2+1:0] in_srem,
    input  logic [(W+fpa_pkg::FRAC_MAX+1)/2-1:0] in_root,
    input  logic [2*((W+fpa_pkg::FRAC_MAX+1)/2)-1:0] in_rad,
    output logic                                 out_valid,
    output fpa_pkg::ctl_t                        out_ctl,
    output logic signed [W+fpa_pkg::FRAC_MAX:0]  out_v,
    output logic [W-1:0]                         out_d,
    output logic [W-1:0]                         out_rem,
    output logic [W+fpa_pkg::FRAC_MAX-1:0]       out_q,
    output logic [(W+fpa_pkg::FRAC_MAX+1)/2+1:0] out_srem,
    output logic [(W+fpa_pkg::FRAC_MAX+1)/2-1:0] out_root,
    output logic [2*((W+fpa_pkg::FRAC_MAX+1)/2)-1:0] out_rad
);

    localparam int DW = W + fpa_pkg::FRAC_MAX;
    localparam int RH = (DW + 1) / 2;
    localparam int RW = 2 * RH;

    logic [W:0]      t;
    logic [W:0]      diff;
    logic            ge;
    logic [W-1:0]    rem_next;
    logic [DW-1:0]   q_next;
    logic [RH+3:0]   s;
    logic [RH+3:0]   trial;
    logic [RH+3:0]   sd;
    logic            ge2;
    logic [RH+1:0]   srem_next;
    logic [RH-1:0]   root_next;
    logic [RW-1:0]   rad_next;
    logic            valid_reg;

    always_comb
    begin
        t        = {in_rem, in_q[DW-1]};
        diff     = t - {1'b0, in_d};
        ge       = (t >= {1'b0, in_d});
        rem_next = ge ? diff[W-1:0] : t[W-1:0];
        q_next   = {in_q[DW-2:0], ge};

        s     = {in_srem, in_rad[RW-1 -: 2]};
        trial = (RH+4)'({in_root, 2'b01});
        sd    = s - trial;
        ge2   = (s >= trial);
        if (DO_SQRT)
        begin
            srem_next = ge2 ? sd[RH+1:0] : s[RH+1:0];
            root_next = {in_root[RH-2:0], ge2};
            rad_next  = {in_rad[RW-3:0], 2'b00};
        end
        else
        begin
            srem_next = in_srem;
            root_next = in_root;
            rad_next  = in_rad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_ctl  <= in_ctl;
            out_v    <= in_v;
            out_d    <= in_d;
            out_rem  <= rem_next;
            out_q    <= q_next;
            out_srem <= srem_next;
            out_root <= root_next;
            out_rad  <= rad_next;
        end
    end

    assign out_valid = valid_reg;

endmodule

/* rtl/fpa_back.sv */
// ----------------------------------------------------------------------------
// fpa_back
// Floor correction of the quotient, result select, range check and wrap.
// ----------------------------------------------------------------------------
module fpa_back #(
    parameter int W = fpa_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  fpa_pkg::ctl_t                        in_ctl,
    input  logic signed [W+fpa_pkg::FRAC_MAX:0]  in_v,
    input  logic [W-1:0]                         in_rem,
    input  logic [W+fpa_pkg::FRAC_MAX-1:0]       in_q,
    input  logic [(W+fpa_pkg::FRAC_MAX+1)/2-1:0] in_root,
    input  logic [fpa_pkg::RWID_W-1:0]           result_width,
    input  logic                                 range_check_enable,
    output logic                                 out_valid,
    output logic signed [31:0]                   result_value,
    output logic                                 result_is_signed,
    output logic [1:0]                           status
);

    localparam int DW = W + fpa_pkg::FRAC_MAX;
    localparam int VW = DW + 1;

    logic signed [VW-1:0] qx;
    logic signed [VW-1:0] vdiv;
    logic signed [VW-1:0] vsel;
    logic [1:0]           st_sel;
    logic                 chk_sel;

    logic                 valid_d_reg;
    logic signed [VW-1:0] v_d_reg;
    logic                 sgn_d_reg;
    logic [1:0]           st_d_reg;
    logic                 chk_d_reg;

    always_comb
    begin
        qx      = VW'(in_q);
        // round toward minus infinity when the signs differ
        vdiv    = in_ctl.qneg ? (-qx - VW'(|in_rem)) : qx;
        vsel    = '0;
        st_sel  = fpa_pkg::ST_OK;
        chk_sel = 1'b0;
        case (in_ctl.op)
            fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_MUL, fpa_pkg::OP_ABS:
            begin
                vsel    = in_v;
                chk_sel = 1'b1;
            end
            fpa_pkg::OP_DIV:
            begin
                if (in_ctl.zdiv)
                begin
                    st_sel = fpa_pkg::ST_DZ;
                end
                else
                begin
                    vsel    = vdiv;
                    chk_sel = 1'b1;
                end
            end
            fpa_pkg::OP_SQRT:
            begin
                if (in_ctl.nroot)
                begin
                    st_sel = fpa_pkg::ST_NROOT;
                end
                else
                begin
                    vsel    = VW'(in_root);
                    chk_sel = 1'b1;
                end
            end
            default:
            begin
                vsel = '0;
            end
        endcase
    end

    logic [fpa_pkg::RWID_W-1:0] wc;
    logic signed [VW-1:0]       hi_s;
    logic signed [VW-1:0]       hi_u;
    logic                       ovf;
    logic [1:0]                 st_next;

    always_comb
    begin
        if (result_width == '0)
        begin
            wc = fpa_pkg::RWID_W'(1);
        end
        else if (result_width > fpa_pkg::RWID_W'(W))
        begin
            wc = fpa_pkg::RWID_W'(W);
        end
        else
        begin
            wc = result_width;
        end
        hi_s = v_d_reg >>> (wc - 1'b1);
        hi_u = v_d_reg >>> wc;
        if (sgn_d_reg)
        begin
            ovf = !((hi_s == '0) || (hi_s == '1));
        end
        else
        begin
            ovf = !((hi_u == '0) || v_d_reg[VW-1]);
        end
        st_next = (chk_d_reg && range_check_enable && ovf) ? fpa_pkg::ST_RANGE : st_d_reg;
    end

    logic valid_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_d_reg <= in_valid;
            valid_e_reg <= valid_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_d_reg          <= vsel;
            sgn_d_reg        <= in_ctl.sgn;
            st_d_reg         <= st_sel;
            chk_d_reg        <= chk_sel;
            result_value     <= 32'(signed'(v_d_reg[W-1:0]));
            result_is_signed <= sgn_d_reg;
            status           <= st_next;
        end
    end

    assign out_valid = valid_e_reg;

endmodule
